### rtl/file_url_percent_decoder_assert.svh
// Assertion macros for the file URL decoder checker.
`ifndef FILE_URL_PERCENT_DECODER_ASSERT_SVH
`define FILE_URL_PERCENT_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FUPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FUPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fupd_pkg.sv
// Constants, codes and helper functions for the file URL percent decoder.
`default_nettype none

package fupd_pkg;

  // Length of the prefix "file://"
  localparam logic [2:0] URL_PFX_LEN = 3'd7;

  // Special bytes
  localparam logic [7:0] ESC_CHAR   = 8'h25;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  // Separator register reset value
  localparam logic [7:0] SEP_RESET = 8'd47;

  // Configuration bus
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_SEPARATOR = 1'b0;

  // Status codes on the last word
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PREFIX = 2'd1;
  localparam logic [1:0] ST_HEX    = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  // Escape phase codes
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Expected byte at a given prefix position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h66;  // f
      3'd1:    c = 8'h69;  // i
      3'd2:    c = 8'h6C;  // l
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h3A;  // :
      3'd5:    c = 8'h2F;  // /
      3'd6:    c = 8'h2F;  // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit value; bit 4 flags a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/file_url_percent_decoder.sv
// Top level of the file URL percent decoder.
// Takes one URL byte per cycle, checks the "file://" prefix, decodes percent
// escapes and maps each unescaped slash after the prefix to the separator
// register. Each accepted byte goes through combinational decode logic into a
// single result register, so the block sustains one byte per clock and any
// result appears in the cycle after its byte is accepted; input is held off
// only while a result waits with res_ready_i low. Data words carry status 0;
// the word for the byte flagged last always appears with the final status, and
// a consumer drops the words of that URL when the status is nonzero.
`default_nettype none

module file_url_percent_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input byte stream
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          in_last_i,
  // Result stream
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [7:0]                         out_byte_o,
  output logic                               out_valid_o,
  output logic                               out_last_o,
  output logic [1:0]                         status_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fupd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fupd_pkg::PDATA_W-1:0]  pwdata,
  output logic [fupd_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import fupd_pkg::*;

  logic [7:0] sep_q;
  logic [2:0] pos_q, pos_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] hn_q, hn_d;
  logic       bad_q, bad_d;
  logic [1:0] err_q, err_d;
  logic       emit;
  logic [7:0] ob;
  logic [4:0] hv;
  logic       in_acc;
  logic       res_load;
  logic       res_valid_q;
  logic [7:0] out_byte_q;
  logic       out_valid_q;
  logic       out_last_q;
  logic [1:0] status_q;
  logic       cfg_wr;

  // Configuration register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1] == REG_SEPARATOR) ?
                  {{(PDATA_W-8){1'b0}}, sep_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_SEPARATOR)) begin
      sep_q <= pwdata[7:0];
    end
  end

  // Accept a byte whenever the result register is free or being drained
  assign in_ready_o = !res_valid_q || res_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode one byte against the stream state
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    hn_d    = hn_q;
    bad_d   = bad_q;
    err_d   = err_q;
    emit    = 1'b0;
    ob      = '0;
    hv      = hex_value(in_byte_i);
    if (err_q == ST_OK) begin
      if (pos_q < URL_PFX_LEN) begin
        if (in_byte_i != prefix_char(pos_q)) begin
          err_d = ST_PREFIX;
        end else begin
          pos_d = pos_q + 3'd1;
          if (in_last_i && (pos_d < URL_PFX_LEN)) begin
            err_d = ST_PREFIX;
          end
        end
      end else begin
        case (phase_q)
          PH_HIGH: begin
            bad_d = hv[4];
            hn_d  = hv[3:0];
            if (in_last_i) begin
              err_d = ST_TRUNC;
            end else begin
              phase_d = PH_LOW;
            end
          end
          PH_LOW: begin
            if (bad_q || hv[4]) begin
              err_d = ST_HEX;
            end else begin
              emit = 1'b1;
              ob   = {hn_q, hv[3:0]};
            end
            phase_d = PH_NONE;
          end
          default: begin
            if (in_byte_i == ESC_CHAR) begin
              if (in_last_i) begin
                err_d = ST_TRUNC;
              end else begin
                phase_d = PH_HIGH;
              end
            end else begin
              emit = 1'b1;
              ob   = (in_byte_i == SLASH_CHAR) ? sep_q : in_byte_i;
            end
          end
        endcase
      end
    end
  end

  // Advance the stream state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_NONE;
      hn_q    <= '0;
      bad_q   <= 1'b0;
      err_q   <= ST_OK;
    end else if (in_acc) begin
      if (in_last_i) begin
        pos_q   <= '0;
        phase_q <= PH_NONE;
        hn_q    <= '0;
        bad_q   <= 1'b0;
        err_q   <= ST_OK;
      end else begin
        pos_q   <= pos_d;
        phase_q <= phase_d;
        hn_q    <= hn_d;
        bad_q   <= bad_d;
        err_q   <= err_d;
      end
    end
  end

  // Hold the result word until it is taken
  assign res_load = in_acc && (emit || in_last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_byte_q  <= ob;
      out_valid_q <= emit;
      out_last_q  <= in_last_i;
      status_q    <= in_last_i ? err_d : ST_OK;
    end
  end

  assign res_valid_o = res_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

### rtl/fupd_checker.sv
// Port-level checker for the file URL percent decoder, with its bind.
`default_nettype none

`include "file_url_percent_decoder_assert.svh"

module fupd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [7:0]                    in_byte_i,
  input wire logic                          in_last_i,
  input wire logic                          res_valid_o,
  input wire logic                          res_ready_i,
  input wire logic [7:0]                    out_byte_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_last_o,
  input wire logic [1:0]                    status_o,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [fupd_pkg::PADDR_W-1:0]  paddr,
  input wire logic [fupd_pkg::PDATA_W-1:0]  pwdata,
  input wire logic [fupd_pkg::PDATA_W-1:0]  prdata,
  input wire logic                          pready
);
  import fupd_pkg::*;

  // A word that is not last carries a decoded byte with clean status
  `FUPD_ASSERT(a_mid_word_is_data, !(res_valid_o && !out_last_o) || (out_valid_o && status_o == ST_OK), "non-last word without data or with status")

  // An error status never comes with decoded data
  `FUPD_ASSERT(a_error_no_data, !(res_valid_o && status_o != ST_OK) || !out_valid_o, "error status with data")

  // An empty last word carries a zero byte
  `FUPD_ASSERT(a_empty_byte_zero, !(res_valid_o && !out_valid_o) || (out_byte_o == 8'h00), "empty word with nonzero byte")

  // A stalled word holds
  `FUPD_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(out_byte_o) && $stable(out_valid_o) && $stable(out_last_o) && $stable(status_o), "stalled word changed")

endmodule

bind file_url_percent_decoder fupd_checker u_fupd_checker (.*);

`default_nettype wire
